@@ rtl/core/pwli_pkg.sv @@
// Package for the piecewise linear interpolation table.
// Holds sizes, command and register codes, and the beat and unit structs.
// No dependencies.
`timescale 1ns / 1ps
package pwli_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 11;
    localparam int PROD_W      = 2 * DATA_WIDTH;
    localparam int CNT_W       = $clog2(PROD_W);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_TABLE_LENGTH  = 1'b0;
    localparam logic REG_DEFAULT_VALUE = 1'b1;

    typedef struct packed {
        logic                          command;
        logic [ADDR_W-1:0]             entry_index;
        logic signed [DATA_WIDTH-1:0]  point_x;
        logic signed [DATA_WIDTH-1:0]  point_y;
        logic signed [DATA_WIDTH-1:0]  query_x;
        logic                          last_query;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  value;
        logic                          out_of_range;
        logic                          batch_end;
    } t_out_item;

    // request to the serial multiply-divide unit: (mplier * mcand) / divisor
    typedef struct packed {
        logic                  start;
        logic [DATA_WIDTH-1:0] mplier;
        logic [DATA_WIDTH:0]   mcand;
        logic [DATA_WIDTH-1:0] divisor;
    } t_md_req;

    typedef struct packed {
        logic                  done;
        logic [DATA_WIDTH:0]   quo;
    } t_md_rsp;

endpackage

@@ rtl/core/piecewise_linear_interpolator_unit.sv @@
// Piecewise linear interpolation table, breakpoints in two 1024x32 RAMs.
// Load: accepted whenever the unit is idle; no result beat.
// Query: first and last breakpoints are read for the range check, then a scan
// (one RAM read per breakpoint scanned, then 32 multiply and 64 divide steps).
// Out-of-range query skips scan and multiply-divide; one query in flight,
// next beat taken the cycle after the result is registered. Reset (sync, low):
// table_length 2, default 0; table RAM not cleared.
`timescale 1ns / 1ps
module piecewise_linear_interpolator_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pwli_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pwli_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import pwli_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_FIRST, S_LAST, S_SCAN, S_WAIT, S_OUT
    } t_state;

    t_state                        r_state;
    logic [LEN_W-1:0]              r_len;
    logic signed [DATA_WIDTH-1:0]  r_dflt;
    logic signed [DATA_WIDTH-1:0]  r_q;
    logic                          r_last;
    logic [ADDR_W-1:0]             r_j;
    logic signed [DATA_WIDTH-1:0]  r_xa;
    logic signed [DATA_WIDTH-1:0]  r_ya;
    logic                          r_neg;
    logic signed [DATA_WIDTH-1:0]  r_res;
    logic                          r_oor;
    logic                          r_out_valid;
    t_out_item                     r_out;
    t_md_req                       r_req;
    t_md_rsp                       md_rsp;

    logic                          in_fire;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_addr;
    logic [ADDR_W-1:0]             last_idx;
    logic signed [DATA_WIDTH-1:0]  x_rd;
    logic signed [DATA_WIDTH-1:0]  y_rd;
    logic signed [DATA_WIDTH:0]    dw;
    logic signed [DATA_WIDTH:0]    dy;
    logic signed [DATA_WIDTH:0]    dx;
    logic signed [DATA_WIDTH+1:0]  sum;
    logic                          scan_adv;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign mem_we      = in_fire && (i_in_data.command == CMD_LOAD);

    // clamp table_length into [2, TABLE_DEPTH] and take the last index
    always_comb begin
        if (r_len < LEN_W'(2)) begin
            last_idx = ADDR_W'(1);
        end else if (r_len > LEN_W'(TABLE_DEPTH)) begin
            last_idx = ADDR_W'(TABLE_DEPTH - 1);
        end else begin
            last_idx = ADDR_W'(r_len - 1'b1);
        end
    end

    // one address for both RAMs: load slot, or the next breakpoint to fetch
    always_comb begin
        unique case (r_state)
            S_IDLE:  mem_addr = (i_in_data.command == CMD_LOAD) ?
                                i_in_data.entry_index : '0;
            S_FIRST: mem_addr = last_idx;
            S_LAST:  mem_addr = ADDR_W'(1);
            S_SCAN:  mem_addr = r_j + 1'b1;
            default: mem_addr = r_j;
        endcase
    end

    pwli_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(DATA_WIDTH)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_in_data.point_x),
        .o_rdata (x_rd)
    );

    pwli_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(DATA_WIDTH)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_in_data.point_y),
        .o_rdata (y_rd)
    );

    pwli_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (md_rsp)
    );

    // segment differences; x1 >= q >= x0 holds once the scan stops
    always_comb begin
        dw  = (DATA_WIDTH+1)'(x_rd) - (DATA_WIDTH+1)'(r_xa);
        dx  = (DATA_WIDTH+1)'(r_q)  - (DATA_WIDTH+1)'(r_xa);
        dy  = (DATA_WIDTH+1)'(y_rd) - (DATA_WIDTH+1)'(r_ya);
        sum = r_neg ? (DATA_WIDTH+2)'(r_ya) - $signed({1'b0, md_rsp.quo})
                    : (DATA_WIDTH+2)'(r_ya) + $signed({1'b0, md_rsp.quo});
    end

    // keep scanning while the query lies right of the fetched breakpoint
    assign scan_adv = (r_j < last_idx) && (r_q > x_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LEN_W'(2);
            r_dflt      <= '0;
            r_out_valid <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            // kick the multiply-divide when the scan stops on a proper segment
            r_req.start <= (r_state == S_SCAN) && !scan_adv && (dw > 0);

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_TABLE_LENGTH:  r_len  <= i_cfg_data[LEN_W-1:0];
                    REG_DEFAULT_VALUE: r_dflt <= $signed(i_cfg_data);
                    default:           r_len  <= r_len;
                endcase
            end

            // drop the output beat once taken, unless a new one replaces it
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_in_data.command == CMD_QUERY)) begin
                        r_q     <= i_in_data.query_x;
                        r_last  <= i_in_data.last_query;
                        r_state <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    // first breakpoint arrives; hold it as the left end
                    r_xa    <= x_rd;
                    r_ya    <= y_rd;
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    if (r_q < r_xa || r_q > x_rd) begin
                        r_res   <= r_dflt;
                        r_oor   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= ADDR_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_adv) begin
                        // advance: this breakpoint becomes the left end
                        r_xa <= x_rd;
                        r_ya <= y_rd;
                        r_j  <= r_j + 1'b1;
                    end else begin
                        r_oor <= 1'b0;
                        if (dw <= 0) begin
                            // zero-width or reversed segment gives its left y
                            r_res   <= r_ya;
                            r_state <= S_OUT;
                        end else begin
                            r_neg         <= dy[DATA_WIDTH];
                            r_req.mplier  <= dx[DATA_WIDTH-1:0];
                            r_req.mcand   <= dy[DATA_WIDTH] ? $unsigned(-dy)
                                                            : $unsigned(dy);
                            r_req.divisor <= dw[DATA_WIDTH-1:0];
                            r_state       <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    // result lies between y0 and y1, so it always fits
                    if (md_rsp.done) begin
                        r_res   <= sum[DATA_WIDTH-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.value        <= r_res;
                        r_out.out_of_range <= r_oor;
                        r_out.batch_end    <= r_last;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

@@ rtl/core/pwli_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pwli_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule

@@ rtl/core/pwli_muldiv.sv @@
// Serial unsigned multiply then restoring divide, one bit per cycle.
// Depends on pwli_pkg.
`timescale 1ns / 1ps
module pwli_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pwli_pkg::t_md_req i_req,
    output pwli_pkg::t_md_rsp o_rsp
);
    import pwli_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} t_mstate;

    t_mstate               r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [PROD_W-1:0]     r_prod;
    logic [DATA_WIDTH-1:0] r_mplier;
    logic [DATA_WIDTH:0]   r_mcand;
    logic [DATA_WIDTH-1:0] r_div;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH:0]   r_quo;
    logic                  r_done;

    logic [PROD_W-1:0]     n_prod;
    logic [DATA_WIDTH:0]   n_trial;

    always_comb begin
        n_prod  = {r_prod[PROD_W-2:0], 1'b0}
                + (r_mplier[DATA_WIDTH-1] ? PROD_W'(r_mcand) : '0);
        n_trial = {r_rem, r_prod[PROD_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            // pulse done on the last divide step
            r_done <= (r_state == M_DIV) && (r_cnt == CNT_W'(PROD_W - 1));
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_prod   <= '0;
                        r_mplier <= i_req.mplier;
                        r_mcand  <= i_req.mcand;
                        r_div    <= i_req.divisor;
                        r_cnt    <= '0;
                        r_state  <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_prod   <= n_prod;
                    r_mplier <= {r_mplier[DATA_WIDTH-2:0], 1'b0};
                    if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_state <= M_DIV;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                    end
                end
                M_DIV: begin
                    // remainder stays below divisor, so the trial fits one extra bit
                    if (n_trial >= {1'b0, r_div}) begin
                        r_rem <= DATA_WIDTH'(n_trial - {1'b0, r_div});
                        r_quo <= {r_quo[DATA_WIDTH-1:0], 1'b1};
                    end else begin
                        r_rem <= n_trial[DATA_WIDTH-1:0];
                        r_quo <= {r_quo[DATA_WIDTH-1:0], 1'b0};
                    end
                    r_prod <= {r_prod[PROD_W-2:0], 1'b0};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(PROD_W - 1)) begin
                        r_state <= M_IDLE;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
